/* rtl/core/hrtp_pkg.sv */
// Shared types and constants of the H.264 RTP packetizer.
`default_nettype none

package hrtp_pkg;

	localparam int START_CODE_LEN = 4;
	localparam int PAYLOAD_START  = 5;

	localparam logic [4:0] FU_A_TYPE        = 5'd28;
	localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;

	// Steps inside one command in the back end
	localparam logic [3:0] STEP_FU_IND     = 4'd12;
	localparam logic [3:0] STEP_FU_HDR     = 4'd13;
	localparam logic [3:0] LAST_STEP_PLAIN = 4'd0;
	localparam logic [3:0] LAST_STEP_SNGL  = 4'd12;
	localparam logic [3:0] LAST_STEP_FRAG  = 4'd14;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] REG_MAX_PAYLOAD  = 2'd0;
	localparam logic [1:0] REG_PAYLOAD_KIND = 2'd1;
	localparam logic [1:0] REG_SOURCE_ID    = 2'd2;

	localparam logic [11:0] MAX_PAYLOAD_RST  = 12'd1400;
	localparam logic [6:0]  PAYLOAD_KIND_RST = 7'd96;

	typedef enum logic [1:0] {
		CMD_PLAIN  = 2'b00,
		CMD_SINGLE = 2'b01,
		CMD_FRAG   = 2'b10
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        pkt_last;
		logic        unit_last;
		logic        marker;
		logic [15:0] seq;
		logic [31:0] stamp;
		logic [7:0]  fu_ind;
		logic [7:0]  fu_hdr;
	} cmd_t;

	typedef struct packed {
		logic [11:0] max_payload;
		logic [6:0]  payload_kind;
		logic [31:0] source_id;
	} cfg_t;

endpackage

`default_nettype wire

/* rtl/core/hrtp_front.sv */
// Front end: accepts unit bytes, tracks unit position and fragments, issues commands.
`default_nettype none

module hrtp_front import hrtp_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,
	input  wire cfg_t        cfg,
	input  wire logic        q_full,
	output logic             push,
	output cmd_t             push_cmd
);

	localparam int L  = LENGTH_BITS;
	localparam int CW = (L > 12) ? L : 12;

	logic [L-1:0]  idx_q;
	logic [L-1:0]  rem_q;
	logic [11:0]   fill_q;
	logic [7:0]    saved_q;
	logic          frag_q;
	logic [31:0]   stamp_q;
	logic [15:0]   seq_q;

	logic [7:0]    b;
	logic [L+15:0] len_ext;
	logic [L-1:0]  len;
	logic [11:0]   mp;
	logic          first, at_hdr, past_hdr;
	logic [L-1:0]  rem;
	logic          last;
	logic          frag_new;
	logic          stop;
	logic          start;
	logic [11:0]   fill_inc;
	logic          pl_frag;
	logic          emit;
	logic          new_pkt;
	logic          accept;
	cmd_t          cmd;

	assign b       = s_tdata[7:0];
	assign len_ext = {{L{1'b0}}, s_tdata[23:8]};
	assign len     = len_ext[L-1:0];
	assign mp      = (cfg.max_payload == 12'd0) ? 12'd1 : cfg.max_payload;

	assign first    = (idx_q == '0);
	assign at_hdr   = (idx_q == L'(START_CODE_LEN));
	assign past_hdr = (idx_q >= L'(PAYLOAD_START));

	always_comb begin
		if (first) begin
			rem = (len != '0) ? len - L'(1) : '0;
		end else begin
			rem = (rem_q != '0) ? rem_q - L'(1) : '0;
		end
	end

	assign last     = (rem == '0);
	assign frag_new = (len >= L'(PAYLOAD_START)) &&
	                  ((CW'(len) - CW'(PAYLOAD_START)) > CW'(mp));
	assign stop     = (CW'(rem) < CW'(mp));
	assign start    = (idx_q == L'(PAYLOAD_START));
	assign fill_inc = fill_q + 12'd1;
	assign pl_frag  = last || (fill_inc >= mp);

	always_comb begin
		cmd           = '0;
		cmd.data      = b;
		cmd.seq       = seq_q + 16'd1;
		cmd.stamp     = stamp_q;
		cmd.fu_ind    = {saved_q[7:5], FU_A_TYPE};
		cmd.fu_hdr    = {start, stop, 1'b0, saved_q[4:0]};
		cmd.kind      = CMD_PLAIN;
		cmd.pkt_last  = last;
		cmd.unit_last = last;
		emit          = 1'b0;
		new_pkt       = 1'b0;
		if (at_hdr && !frag_q) begin
			emit       = 1'b1;
			new_pkt    = 1'b1;
			cmd.kind   = CMD_SINGLE;
			cmd.marker = 1'b1;
		end else if (past_hdr) begin
			emit = 1'b1;
			if (frag_q) begin
				cmd.pkt_last = pl_frag;
				if (fill_q == 12'd0) begin
					new_pkt    = 1'b1;
					cmd.kind   = CMD_FRAG;
					cmd.marker = stop;
				end
			end
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && emit;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rem_q   <= '0;
			fill_q  <= '0;
			saved_q <= '0;
			frag_q  <= 1'b0;
			stamp_q <= '0;
			seq_q   <= '0;
		end else if (accept) begin
			if (first) begin
				stamp_q <= s_tdata[55:24];
			end
			if (at_hdr) begin
				saved_q <= b;
			end
			if (new_pkt) begin
				seq_q <= seq_q + 16'd1;
			end
			// close the unit on its final byte
			if (last) begin
				idx_q  <= '0;
				rem_q  <= '0;
				fill_q <= '0;
				frag_q <= 1'b0;
			end else begin
				idx_q <= idx_q + L'(1);
				rem_q <= rem;
				if (first) begin
					frag_q <= frag_new;
					fill_q <= '0;
				end else if (past_hdr && frag_q) begin
					fill_q <= pl_frag ? 12'd0 : fill_inc;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/hrtp_queue.sv */
// Command queue between the front end and the back end.
`default_nettype none

module hrtp_queue import hrtp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head,
	input  wire logic pop
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command popped from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + QCNT_W'(1)))
		else $error("queue count did not advance on push");

endmodule

`default_nettype wire

/* rtl/core/hrtp_back.sv */
// Back end: expands each command into its RTP header and FU bytes, if any, and its payload byte.
`default_nettype none

module hrtp_back import hrtp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       head_valid,
	input  wire cmd_t       head,
	output logic            pop,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast,
	output logic            m_tuser
);

	logic [3:0] step_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       user_q;

	logic [3:0] last_step;
	logic       at_end;
	logic       adv;
	logic [7:0] hdr_byte;

	always_comb begin
		unique case (head.kind)
			CMD_PLAIN:  last_step = LAST_STEP_PLAIN;
			CMD_SINGLE: last_step = LAST_STEP_SNGL;
			CMD_FRAG:   last_step = LAST_STEP_FRAG;
			default:    last_step = LAST_STEP_PLAIN;
		endcase
	end

	always_comb begin
		case (step_q)
			4'd0:        hdr_byte = RTP_VERSION_BYTE;
			4'd1:        hdr_byte = {head.marker, cfg.payload_kind};
			4'd2:        hdr_byte = head.seq[15:8];
			4'd3:        hdr_byte = head.seq[7:0];
			4'd4:        hdr_byte = head.stamp[31:24];
			4'd5:        hdr_byte = head.stamp[23:16];
			4'd6:        hdr_byte = head.stamp[15:8];
			4'd7:        hdr_byte = head.stamp[7:0];
			4'd8:        hdr_byte = cfg.source_id[31:24];
			4'd9:        hdr_byte = cfg.source_id[23:16];
			4'd10:       hdr_byte = cfg.source_id[15:8];
			4'd11:       hdr_byte = cfg.source_id[7:0];
			STEP_FU_IND: hdr_byte = head.fu_ind;
			STEP_FU_HDR: hdr_byte = head.fu_hdr;
			default:     hdr_byte = head.data;
		endcase
	end

	assign at_end = (step_q == last_step);
	assign adv    = head_valid && (!valid_q || m_tready);
	assign pop    = adv && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (adv) begin
				valid_q <= 1'b1;
				step_q  <= at_end ? 4'd0 : step_q + 4'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload byte closes the command; header bytes never flag an end
	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q <= at_end ? head.data : hdr_byte;
			last_q <= at_end && head.pkt_last;
			user_q <= at_end && head.unit_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = byte_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

endmodule

`default_nettype wire

/* rtl/core/h264_rtp_packetizer_unit.sv */
// Top level of the H.264 RTP packetizer: configuration registers and the three stages.
`default_nettype none

// Takes an Annex-B NAL unit one byte per transfer (each transfer carries the byte, the
// unit length and the timestamp; length and timestamp are used at the first byte only)
// and produces RTP packets one byte per transfer, header first, with tlast on the final
// byte of each packet and tuser on the final byte of the unit. The start code is dropped.
// Units whose length minus five fits max_payload go out as one packet with the marker
// set; longer ones go out as FU-A fragments. Payload bytes pass at one per cycle while
// the output is not stalled. Each packet start adds 12 header bytes (single packet)
// or 14 (FU-A fragment) on the output side; the input keeps going meanwhile until
// the four-entry command queue between the front and back ends fills. Bytes that
// produce no output (start code, short units, the saved NAL header of a fragmented
// unit) push no command. Configuration must be written only while no unit is in flight.
module h264_rtp_packetizer_unit import hrtp_pkg::*; #(
	parameter int LENGTH_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,   // nal_byte[7:0], unit_length[23:8], stamp[55:24]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // out_byte[7:0]
	output logic             m_tlast,
	output logic             m_tuser,   // unit_last
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic head_valid;
	cmd_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload  <= MAX_PAYLOAD_RST;
			cfg_q.payload_kind <= PAYLOAD_KIND_RST;
			cfg_q.source_id    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD:  cfg_q.max_payload  <= cfg_wdata[11:0];
				REG_PAYLOAD_KIND: cfg_q.payload_kind <= cfg_wdata[6:0];
				REG_SOURCE_ID:    cfg_q.source_id    <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	hrtp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	hrtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	hrtp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire
